[hw/rtl/rtd_pkg.sv]
// Shared types, constants and the PT1000 resistance table for the RTD converter.
`default_nettype none

package rtd_pkg;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int RES_W     = 16;
  localparam int TEMP_W    = 11;
  localparam int DECI_W    = 14;
  localparam int ROM_IDX_W = 7;

  // Register map: one register, index taken from paddr[2]
  localparam int          PADDR_W        = 3;
  localparam logic        CFG_IDX_OFFSET = 1'b0;
  localparam logic [15:0] OFFSET_RESET   = 16'd200;

  // Arithmetic constants
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 16'hFFFF;
  localparam int                  ROM_SIZE     = 126;
  localparam int                  ROM_MIN_TEMP = -25;
  localparam logic [ROM_IDX_W-1:0] ROM_LAST     = 7'(ROM_SIZE - 1);
  localparam logic [ROM_IDX_W-1:0] ROM_MID_INIT = 7'((ROM_SIZE - 1) / 2);
  localparam logic [TEMP_W:0]      TEMP_BIAS    = 12'(-ROM_MIN_TEMP * 10);
  localparam logic [3:0]           GUARD_LAST   = 4'd15;

  // PT1000 resistance in deci-ohms, one entry per degree from -25 C to 100 C
  localparam logic [DECI_W-1:0] PT_ROM [ROM_SIZE] = '{
     9019,  9059,  9098,  9137,  9177,  9216,  9255,  9295,  9334,  9373,
     9412,  9452,  9491,  9530,  9569,  9609,  9648,  9687,  9726,  9765,
     9804,  9844,  9883,  9922,  9961, 10000, 10039, 10078, 10117, 10156,
    10195, 10234, 10273, 10312, 10351, 10390, 10429, 10468, 10507, 10546,
    10585, 10624, 10663, 10702, 10740, 10779, 10818, 10857, 10896, 10935,
    10973, 11012, 11051, 11090, 11128, 11167, 11206, 11245, 11283, 11322,
    11361, 11399, 11438, 11477, 11515, 11554, 11593, 11631, 11670, 11708,
    11747, 11785, 11824, 11862, 11901, 11940, 11978, 12016, 12055, 12093,
    12132, 12170, 12209, 12247, 12286, 12324, 12362, 12401, 12439, 12477,
    12516, 12554, 12592, 12631, 12669, 12707, 12745, 12784, 12822, 12860,
    12898, 12937, 12975, 13013, 13051, 13089, 13127, 13166, 13204, 13242,
    13280, 13318, 13356, 13394, 13432, 13470, 13508, 13546, 13584, 13622,
    13660, 13698, 13736, 13774, 13812, 13850
  };

  // Table lookup; indexes past the end read the last entry.
  function automatic logic [DECI_W-1:0] rom_entry(input logic [ROM_IDX_W-1:0] idx);
    if (idx > ROM_LAST) begin
      return PT_ROM[ROM_SIZE-1];
    end
    return PT_ROM[idx];
  endfunction

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_sample;
    logic res_start;
    logic res_take;
    logic deci_load;
    logic search_step;
    logic interp_start;
    logic out_load;
  } rtd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic res_sat;
    logic div_done;
    logic search_last;
    logic interp_div;
  } rtd_status_t;

endpackage

`default_nettype wire

[hw/rtl/rtd_sample_if.sv]
// Input channel carrying one ADC sample per beat.
`default_nettype none

interface rtd_sample_if import rtd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/rtd_result_if.sv]
// Output channel carrying one temperature result per beat.
`default_nettype none

interface rtd_result_if import rtd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_deci_c;
  logic [RES_W-1:0]         resistance_ohm;
  logic                     fault;

  modport source (output valid, output temperature_deci_c, output resistance_ohm,
                  output fault, input ready);
  modport sink   (input valid, input temperature_deci_c, input resistance_ohm,
                  input fault, output ready);
endinterface

`default_nettype wire

[hw/rtl/rtd_adc_to_temperature_unit.sv]
// Top level of the RTD sample to temperature converter with its register port.
//
//   Channel  Role    Beat contents
//   -------  ------  ----------------------------------------------------
//   sample   sink    adc_sample (16 bits, unsigned)
//   result   source  temperature_deci_c (11 bits, signed), resistance_ohm
//                    (16 bits), fault (1 bit)
//   APB      slave   offset_resistor_ohm at byte address 0
//
// The product is registered as a sample is accepted. The result is loaded after the
// resistance division in the shared serial divider, the table search steps, the
// interpolation division in the same divider and the RES, DECI, ISETUP and DONE states;
// a new sample is taken only once the controller is back in idle. A saturated
// resistance or an exact table hit skips one division.
// Reset clears the controller and sets the offset register to 200 ohms.
// A result waits in the output register while the next sample is taken in; the
// controller holds its finished result until that register is free.
`default_nettype none

module rtd_adc_to_temperature_unit import rtd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  rtd_sample_if.sink              sample,
  rtd_result_if.source            result
);

  logic [15:0] offset_resistor_ohm;
  logic        cfg_write;
  rtd_cmd_t    cmd;
  rtd_status_t status;

  // Register port: write on the access cycle, read returns the register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == CFG_IDX_OFFSET) ? {16'd0, offset_resistor_ohm} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_resistor_ohm <= OFFSET_RESET;
    end else if (cfg_write && (paddr[2] == CFG_IDX_OFFSET)) begin
      offset_resistor_ohm <= pwdata[15:0];
    end
  end

  // Sequencer
  rtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and output payload
  rtd_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .adc_sample         (sample.adc_sample),
    .offset             (offset_resistor_ohm),
    .temperature_deci_c (result.temperature_deci_c),
    .resistance_ohm     (result.resistance_ohm),
    .fault              (result.fault)
  );

endmodule

`default_nettype wire

[hw/rtl/rtd_div.sv]
// Restoring serial divider, one quotient bit per cycle, 16 quotient bits.
`default_nettype none

module rtd_div import rtd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] rem_init,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic [15:0] rem;
  logic [15:0] shreg;
  logic [15:0] dvs;
  logic [4:0]  count;
  logic [16:0] trial;
  logic        fits;

  // One trial subtraction: shift the next dividend bit into the remainder
  assign trial = {rem, shreg[15]};
  assign fits  = trial >= {1'b0, dvs};

  // Step counter is control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 5'd0;
    end else if (start) begin
      count <= 5'd16;
    end else if (count != 5'd0) begin
      count <= count - 5'd1;
    end
  end

  // Remainder and the shift register that turns dividend bits into quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      shreg <= dividend;
      dvs   <= divisor;
    end else if (count != 5'd0) begin
      rem   <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      shreg <= {shreg[14:0], fits};
    end
  end

  assign done     = (count == 5'd0);
  assign quotient = shreg;

endmodule

`default_nettype wire

[hw/rtl/rtd_datapath.sv]
// Datapath: multiply, resistance division, deci-ohm clamp, table search, interpolation.
`default_nettype none

module rtd_datapath import rtd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rtd_cmd_t            cmd,
  output rtd_status_t              status,
  input  wire logic [SAMPLE_W-1:0] adc_sample,
  input  wire logic [15:0]         offset,
  output logic signed [TEMP_W-1:0] temperature_deci_c,
  output logic [RES_W-1:0]         resistance_ohm,
  output logic                     fault
);

  logic [31:0]          product;
  logic [15:0]          denom;
  logic [RES_W-1:0]     res;
  logic                 res_fault;
  logic [DECI_W-1:0]    deci;
  logic [ROM_IDX_W-1:0] lo;
  logic [ROM_IDX_W-1:0] hi;
  logic [ROM_IDX_W-1:0] mid;
  logic [3:0]           guard;
  logic                 mode_up;
  logic                 mode_dn;
  logic [TEMP_W-1:0]    base;

  logic                 res_sat;
  logic                 div_start;
  logic [15:0]          div_rem_init;
  logic [15:0]          div_dividend;
  logic [15:0]          div_divisor;
  logic                 div_done;
  logic [15:0]          div_q;

  logic [19:0]          res10;
  logic [15:0]          res10_sat;
  logic [DECI_W-1:0]    deci_next;

  logic [DECI_W-1:0]    mid_val;
  logic [ROM_IDX_W-1:0] lo_next;
  logic [ROM_IDX_W-1:0] hi_next;
  logic [ROM_IDX_W:0]   span_sum;
  logic [ROM_IDX_W-1:0] mid_next;
  logic                 search_last;

  logic [DECI_W-1:0]    e_up;
  logic [DECI_W-1:0]    e_dn;
  logic                 up;
  logic                 dn;
  logic [DECI_W-1:0]    gap;
  logic [15:0]          interp_num;
  logic [15:0]          interp_dvs;
  logic [TEMP_W:0]      base_wide;
  logic [TEMP_W-1:0]    temp_calc;

  // Quotient overflows 16 bits exactly when the upper product half reaches the
  // divisor; a full-scale sample gives a zero divisor and lands here as well.
  assign res_sat = product[31:16] >= denom;

  // Saturating times ten, then clamp into the table range
  assign res10     = 20'({res, 3'b000}) + 20'({res, 1'b0});
  assign res10_sat = (res10 > 20'h0FFFF) ? 16'hFFFF : res10[15:0];
  always_comb begin
    if (res10_sat < {2'b00, rom_entry('0)}) begin
      deci_next = rom_entry('0);
    end else if (res10_sat > {2'b00, rom_entry(ROM_LAST)}) begin
      deci_next = rom_entry(ROM_LAST);
    end else begin
      deci_next = res10_sat[DECI_W-1:0];
    end
  end

  // One halving step of the table search
  assign mid_val     = rom_entry(mid);
  assign lo_next     = (mid_val > deci) ? lo : mid;
  assign hi_next     = (mid_val > deci) ? mid : hi;
  assign span_sum    = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next    = span_sum[ROM_IDX_W:1];
  assign search_last = (rom_entry(mid_next) == deci) || (lo_next == mid_next) ||
                       (guard == GUARD_LAST);

  // Interpolation operands around the found entry
  assign e_up       = rom_entry(mid + 7'd1);
  assign e_dn       = rom_entry(mid - 7'd1);
  assign up         = (deci > mid_val) && (mid < ROM_LAST);
  assign dn         = (deci < mid_val) && (mid != '0);
  assign gap        = up ? (deci - mid_val) : (mid_val - deci);
  assign interp_num = 16'({gap, 3'b000}) + 16'({gap, 1'b0});
  assign interp_dvs = up ? 16'(e_up - mid_val) : 16'(mid_val - e_dn);
  assign base_wide  = 12'({mid, 3'b000}) + 12'({mid, 1'b0}) - TEMP_BIAS;

  // The divider serves the resistance and the interpolation in turn
  assign div_start    = (cmd.res_start && !res_sat) || (cmd.interp_start && (up || dn));
  assign div_rem_init = cmd.interp_start ? 16'd0 : product[31:16];
  assign div_dividend = cmd.interp_start ? interp_num : product[15:0];
  assign div_divisor  = cmd.interp_start ? interp_dvs : denom;

  rtd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Final temperature, modulo the field width
  always_comb begin
    if (mode_up) begin
      temp_calc = base + div_q[TEMP_W-1:0];
    end else if (mode_dn) begin
      temp_calc = base - div_q[TEMP_W-1:0];
    end else begin
      temp_calc = base;
    end
  end

  // Working registers, loaded under the controller's commands
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      product <= {16'd0, adc_sample} * {16'd0, offset};
      denom   <= SAMPLE_MAX - adc_sample;
    end
    if (cmd.res_start) begin
      res_fault <= res_sat;
      if (res_sat) begin
        res <= 16'hFFFF;
      end
    end
    if (cmd.res_take) begin
      res <= div_q;
    end
    if (cmd.deci_load) begin
      deci  <= deci_next;
      lo    <= '0;
      hi    <= ROM_LAST;
      mid   <= ROM_MID_INIT;
      guard <= 4'd0;
    end
    if (cmd.search_step) begin
      lo    <= lo_next;
      hi    <= hi_next;
      mid   <= mid_next;
      guard <= guard + 4'd1;
    end
    if (cmd.interp_start) begin
      mode_up <= up;
      mode_dn <= dn;
      base    <= base_wide[TEMP_W-1:0];
    end
    if (cmd.out_load) begin
      temperature_deci_c <= temp_calc;
      resistance_ohm     <= res;
      fault              <= res_fault;
    end
  end

  assign status.res_sat     = res_sat;
  assign status.div_done    = div_done;
  assign status.search_last = search_last;
  assign status.interp_div  = up || dn;

endmodule

`default_nettype wire

[hw/rtl/rtd_ctrl.sv]
// Controller state machine sequencing the datapath and the output register.
`default_nettype none

module rtd_ctrl import rtd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire rtd_status_t status,
  output rtd_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RES    = 3'd1;
  localparam logic [2:0] S_DIV1   = 3'd2;
  localparam logic [2:0] S_DECI   = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_ISETUP = 3'd5;
  localparam logic [2:0] S_DIV2   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // The output register is free when empty or being emptied this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = S_RES;
        end
      end
      S_RES: begin
        cmd.res_start = 1'b1;
        state_next    = status.res_sat ? S_DECI : S_DIV1;
      end
      S_DIV1: begin
        if (status.div_done) begin
          cmd.res_take = 1'b1;
          state_next   = S_DECI;
        end
      end
      S_DECI: begin
        cmd.deci_load = 1'b1;
        state_next    = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_last) begin
          state_next = S_ISETUP;
        end
      end
      S_ISETUP: begin
        cmd.interp_start = 1'b1;
        state_next       = status.interp_div ? S_DIV2 : S_DONE;
      end
      S_DIV2: begin
        if (status.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[tb/tb_rtd_adc_to_temperature_unit.sv]
// Self-checking testbench for the RTD sample to temperature converter.
`timescale 1ns / 1ps

module tb_rtd_adc_to_temperature_unit;
  import rtd_pkg::*;

  localparam int IDLE_PCT       = 25;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int PHASE_GAP      = 8;
  localparam logic [PADDR_W-1:0] OFFSET_REG_ADDR = PADDR_W'(4 * int'(CFG_IDX_OFFSET));
  localparam logic APB_WRITE = 1'b1;
  localparam logic APB_READ  = 1'b0;

  // One conversion: the sample that went in and the result that should come out.
  typedef struct {
    logic [SAMPLE_W-1:0] adc;
    logic [TEMP_W-1:0]   temp;
    logic [RES_W-1:0]    ohms;
    logic                fault;
  } reading_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  rtd_sample_if sample_ch ();
  rtd_result_if result_ch ();

  rtd_adc_to_temperature_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sample  (sample_ch),
    .result  (result_ch)
  );

  logic [SAMPLE_W-1:0] samples_to_send [$];
  reading_t            expected_readings [$];
  logic [15:0]         divider_ohm;
  logic                no_gaps;
  logic                sample_fire;
  int                  samples_queued;
  int                  samples_taken;
  int                  readings_checked;
  int                  fault_count;
  int                  clamp_count;
  int                  settings_used;
  int                  error_count;
  int                  quiet_cycles;

  // Temperature the converter should report for one sample and divider resistor.
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] adc,
                                               input logic [15:0] ohm);
    reading_t        rd;
    longint unsigned quot;
    int unsigned     deci;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    int unsigned     probe;
    int unsigned     span;
    int              degc;
    logic            found;
    rd.adc   = adc;
    rd.fault = 1'b0;
    // Resistance from the divider ratio; full scale and overflow saturate.
    if (adc == SAMPLE_MAX) begin
      rd.ohms  = '1;
      rd.fault = 1'b1;
    end else begin
      quot = (64'(adc) * 64'(ohm)) / 64'(SAMPLE_MAX - adc);
      if (quot > 64'hFFFF) begin
        rd.ohms  = '1;
        rd.fault = 1'b1;
      end else begin
        rd.ohms = quot[15:0];
      end
    end
    // Deci-ohms, saturated, then held to the span of the table.
    deci = 32'(rd.ohms) * 10;
    if (deci > 32'hFFFF) begin
      deci = 32'hFFFF;
    end
    if (deci < PT_ROM[0]) begin
      deci = PT_ROM[0];
    end else if (deci > PT_ROM[ROM_SIZE-1]) begin
      deci = PT_ROM[ROM_SIZE-1];
    end
    // Halving search for the bracketing entry, stopping on an exact hit.
    lo    = 0;
    hi    = ROM_SIZE - 1;
    mid   = (lo + hi) / 2;
    found = 1'b0;
    for (probe = 0; probe < 16 && !found; probe++) begin
      if (PT_ROM[mid] > deci) begin
        hi = mid;
      end else begin
        lo = mid;
      end
      mid = (lo + hi) / 2;
      if (PT_ROM[mid] == deci || lo == mid) begin
        found = 1'b1;
      end
    end
    // Whole degrees from the index, tenths by truncating interpolation.
    degc = (int'(mid) + ROM_MIN_TEMP) * 10;
    if (deci > PT_ROM[mid] && mid + 1 < ROM_SIZE) begin
      span = PT_ROM[mid+1] - PT_ROM[mid];
      degc = degc + int'(((deci - PT_ROM[mid]) * 10) / span);
    end else if (deci < PT_ROM[mid] && mid > 0) begin
      span = PT_ROM[mid] - PT_ROM[mid-1];
      degc = degc - int'(((PT_ROM[mid] - deci) * 10) / span);
    end
    rd.temp = degc[TEMP_W-1:0];
    return rd;
  endfunction

  // Sample that makes the divider show roughly the wanted sensor resistance.
  function automatic logic [SAMPLE_W-1:0] sample_for_ohms(input logic [15:0] ohm,
                                                          input int unsigned target);
    longint unsigned s;
    s = (64'd65535 * target + (target + ohm) / 2) / (target + ohm);
    if (s > 64'hFFFF) begin
      s = 64'hFFFF;
    end
    return s[15:0];
  endfunction

  // Mostly samples inside or just beyond the table, some at the rails, some anywhere.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [15:0] ohm);
    int unsigned roll;
    int unsigned s;
    roll = $urandom_range(99);
    if (roll < 60) begin
      s = sample_for_ohms(ohm, $urandom_range(1450, 850));
      s = s + $urandom_range(4) - 2;
      if (s > 65535) begin
        s = (s > 32'h8000_0000) ? 0 : 65535;
      end
    end else if (roll < 68) begin
      s = $urandom_range(15);
    end else if (roll < 76) begin
      s = 65535 - $urandom_range(15);
    end else begin
      s = $urandom_range(65535);
    end
    return s[15:0];
  endfunction

  task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
    samples_to_send.push_back(s);
    samples_queued++;
  endtask

  task automatic queue_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      queue_sample(pick_sample(divider_ohm));
    end
  endtask

  // Block until every queued sample has been converted and checked.
  task automatic drain;
    @(negedge clk);
    while (samples_taken != samples_queued || expected_readings.size() != 0) begin
      @(negedge clk);
    end
    repeat (PHASE_GAP) @(negedge clk);
  endtask

  // One register transfer: setup cycle, then access cycle (pready is always high).
  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_offset_reg;
    logic [31:0] rb;
    apb_access(APB_READ, OFFSET_REG_ADDR, 32'h0, rb);
    if (rb[15:0] !== divider_ohm) begin
      $display("%0t: offset register read back: expected %0d, actual %0d",
               $time, divider_ohm, rb[15:0]);
      error_count++;
    end
  endtask

  task automatic set_divider(input logic [31:0] word);
    logic [31:0] unused;
    apb_access(APB_WRITE, OFFSET_REG_ADDR, word, unused);
    divider_ohm = word[15:0];
    settings_used++;
    check_offset_reg();
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample driver and result back-pressure, both moved on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid  <= 1'b0;
      result_ch.ready  <= 1'b0;
    end else begin
      if (!sample_ch.valid || sample_fire) begin
        if (samples_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          sample_ch.valid      <= 1'b1;
          sample_ch.adc_sample <= samples_to_send.pop_front();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
      result_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: check each result beat against the oldest prediction, then predict new beats.
  always @(posedge clk) begin
    reading_t exp_rd;
    reading_t new_rd;
    if (rst) begin
      sample_fire <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        readings_checked++;
        if (expected_readings.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: temp %0d res %0d fault %0b",
                   $time, $signed(result_ch.temperature_deci_c),
                   result_ch.resistance_ohm, result_ch.fault);
          error_count++;
        end else begin
          exp_rd = expected_readings.pop_front();
          if (result_ch.temperature_deci_c !== exp_rd.temp) begin
            $display("%0t: sample %0d temperature: expected %0d, actual %0d", $time,
                     exp_rd.adc, $signed(exp_rd.temp), $signed(result_ch.temperature_deci_c));
            error_count++;
          end
          if (result_ch.resistance_ohm !== exp_rd.ohms) begin
            $display("%0t: sample %0d resistance: expected %0d, actual %0d", $time,
                     exp_rd.adc, exp_rd.ohms, result_ch.resistance_ohm);
            error_count++;
          end
          if (result_ch.fault !== exp_rd.fault) begin
            $display("%0t: sample %0d fault: expected %0b, actual %0b", $time,
                     exp_rd.adc, exp_rd.fault, result_ch.fault);
            error_count++;
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        new_rd = predict_reading(sample_ch.adc_sample, divider_ohm);
        expected_readings.push_back(new_rd);
        samples_taken++;
        if (new_rd.fault) begin
          fault_count++;
        end
        if ($signed(new_rd.temp) == -250 || $signed(new_rd.temp) == 1000) begin
          clamp_count++;
        end
      end
      sample_fire <= sample_ch.valid && sample_ch.ready;
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus: reset, directed samples, then random phases under several resistor values.
  initial begin
    int k;
    int unsigned edge_ohms [10];
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.adc_sample = '0;
    result_ch.ready      = 1'b0;
    sample_fire          = 1'b0;
    no_gaps              = 1'b0;
    divider_ohm          = OFFSET_RESET;
    samples_queued       = 0;
    samples_taken        = 0;
    readings_checked     = 0;
    fault_count          = 0;
    clamp_count          = 0;
    settings_used        = 1;
    error_count          = 0;
    quiet_cycles         = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset value of the divider register, then the rails and the table edges.
    check_offset_reg();
    queue_sample(16'h0000);
    queue_sample(16'h0001);
    queue_sample(16'h5555);
    queue_sample(16'hAAAA);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'hFFFE);
    queue_sample(SAMPLE_MAX);
    // Below, on and above both table ends, mid table, and the deci-ohm overflow point.
    edge_ohms = '{890, 901, 902, 903, 1000, 1100, 1385, 1386, 6553, 6554};
    for (k = 0; k < 10; k++) begin
      queue_sample(sample_for_ohms(divider_ohm, edge_ohms[k]));
    end
    queue_random(100);
    drain();

    // Typical PT1000 divider, run back to back with no idling on either side.
    set_divider(32'd1000);
    no_gaps = 1'b1;
    queue_random(200);
    drain();
    no_gaps = 1'b0;

    // Smallest and largest divider resistor.
    set_divider(32'd1);
    queue_sample(SAMPLE_MAX);
    queue_sample(16'h0000);
    queue_random(100);
    drain();
    set_divider(32'hFFFF);
    queue_sample(16'h0000);
    queue_sample(16'h8000);
    queue_random(100);
    drain();

    // Random resistor values, with junk in the unused upper bits of the write.
    for (k = 0; k < 3; k++) begin
      set_divider({16'($urandom), 16'($urandom_range(65535, 1))});
      queue_random(115);
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Converted %0d samples (%0d results checked) under %0d divider resistor values.",
             samples_taken, readings_checked, settings_used);
    $display("%0d results flagged a fault and %0d temperatures sat at a table edge.",
             fault_count, clamp_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
